// ===== sv/tbs_pkg.sv =====
// tbs_pkg: widths and handshake structs shared by the band smoother modules
// no dependencies; imported by tbs_div and triangular_band_smoother_core
`timescale 1ns / 1ps

package tbs_pkg;

  // band value, Q7.8 signed
  localparam int VAL_W = 16;
  // smoothing radius register
  localparam int RAD_W = 3;
  // kernel weight, radius + 1 at most
  localparam int WT_W = RAD_W + 1;
  // weight sum, at most (radius + 1) squared
  localparam int DEN_W = 2 * RAD_W + 1;
  // weighted sum of up to 15 taps of weight up to 8
  localparam int NUM_W = VAL_W + DEN_W;
  // rounded dividend 2 * |num| + den
  localparam int DVD_W = NUM_W + 1;
  // two quotient bits per divider cycle
  localparam int QDIV_STEPS = DVD_W / 2;
  localparam int CNT_W = $clog2(QDIV_STEPS);
  // partial remainder after shift, divisor is 2 * den
  localparam int REM_W = DEN_W + 2;

  // one division request per band
  typedef struct packed {
    logic                    vld;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    logic                    last;
  } div_req_t;

  // one smoothed word out of the divider
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] value;
    logic             last;
  } div_rsp_t;

endpackage

// ===== sv/triangular_band_smoother_core.sv =====
// triangular_band_smoother_core: band store, kernel walk and result sequencing
// depends on tbs_pkg and tbs_div
`timescale 1ns / 1ps

// Usage
//   Bands of one frame arrive lowest first on band_value_i; a word is taken
//   at each clock edge with start high and busy low, one per cycle while
//   loading. The last band of the frame raises busy, and the block then
//   emits NUM_BANDS smoothed words in band order on smoothed_value_o, each
//   for one cycle with result_valid_o high, last_band_o marking the final.
//   Each band reads up to 2r+1 neighbors, clipped at the band edges, from
//   the band memory, one read a cycle, then the divider forms the rounded
//   average; the walk of the next band overlaps the division of the current
//   one. busy falls once the last word has been shown, and the next frame
//   may start after that. The radius is to be written on the cfg channel
//   (always ready) between frames; the block itself does not enforce this.
//   Reset clears the radius and the band count; the memory is not cleared
//   since every entry is written before a frame is read. Results cannot be
//   held off by the receiver.

module triangular_band_smoother_core
  import tbs_pkg::*;
#(
  parameter int NUM_BANDS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] band_value_i,
  output logic                    result_valid_o,
  output logic signed [VAL_W-1:0] smoothed_value_o,
  output logic                    last_band_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [RAD_W-1:0]        cfg_data_i
);

  localparam int BW = $clog2(NUM_BANDS);
  localparam int EW = ((BW > RAD_W) ? BW : RAD_W) + 1;
  localparam logic [BW-1:0] LAST_IDX = BW'(NUM_BANDS - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [RAD_W-1:0]        rad_q;
  logic [BW-1:0]           load_cnt_q, load_cnt_d;
  logic [BW-1:0]           band_q, band_d;
  logic [BW-1:0]           addr_q, addr_d;
  logic [BW-1:0]           hi_q, hi_d;

  logic [VAL_W-1:0]        mem_q [NUM_BANDS];
  logic [VAL_W-1:0]        rd_data_q;
  logic                    rd_vld_q;
  logic                    rd_last_q;
  logic [WT_W-1:0]         rd_wt_q;

  logic signed [NUM_W-1:0] acc_num_q, acc_num_d;
  logic [DEN_W-1:0]        acc_den_q, acc_den_d;
  logic                    acc_done_q, acc_done_d;

  logic                    accept;
  logic                    div_busy;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic [EW-1:0]           band_x, rad_x, sum_x;
  logic [BW-1:0]           lo, hi;
  logic [BW-1:0]           tap_dist;
  logic [WT_W-1:0]         wt;
  logic signed [VAL_W+WT_W:0] prod;

  assign accept      = start && (state_q == ST_IDLE);
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rad_q <= cfg_data_i;
    end
  end

  // clipped window of the current band
  always_comb begin
    band_x = EW'(band_q);
    rad_x  = EW'(rad_q);
    sum_x  = band_x + rad_x;
    lo     = (band_x < rad_x) ? '0 : BW'(band_x - rad_x);
    hi     = (sum_x > EW'(LAST_IDX)) ? LAST_IDX : BW'(sum_x);
  end

  // kernel weight of the tap being read
  always_comb begin
    tap_dist = (addr_q >= band_q) ? (addr_q - band_q) : (band_q - addr_q);
    wt       = WT_W'(rad_q) + 1'b1 - WT_W'(tap_dist);
  end

  // weighted accumulate of returning read words
  assign prod = $signed(rd_data_q) * $signed({1'b0, rd_wt_q});

  always_comb begin
    acc_num_d  = acc_num_q;
    acc_den_d  = acc_den_q;
    acc_done_d = acc_done_q;
    if (state_q == ST_SETUP) begin
      acc_num_d  = '0;
      acc_den_d  = '0;
      acc_done_d = 1'b0;
    end else if (rd_vld_q) begin
      acc_num_d  = acc_num_q + NUM_W'(prod);
      acc_den_d  = acc_den_q + DEN_W'(rd_wt_q);
      acc_done_d = rd_last_q;
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    band_d     = band_q;
    addr_d     = addr_q;
    hi_d       = hi_q;
    div_req    = '0;
    div_req.num  = acc_num_q;
    div_req.den  = acc_den_q;
    div_req.last = (band_q == LAST_IDX);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (load_cnt_q == LAST_IDX) begin
            load_cnt_d = '0;
            band_d     = '0;
            state_d    = ST_SETUP;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      ST_SETUP: begin
        addr_d  = lo;
        hi_d    = hi;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        addr_d = addr_q + 1'b1;
        if (addr_q == hi_q) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (acc_done_q && !div_busy) begin
          div_req.vld = 1'b1;
          if (band_q == LAST_IDX) begin
            state_d = ST_FIN;
          end else begin
            band_d  = band_q + 1'b1;
            state_d = ST_SETUP;
          end
        end
      end
      ST_FIN: begin
        if (div_rsp.vld && div_rsp.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      load_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      rd_vld_q   <= (state_q == ST_WALK);
      acc_done_q <= acc_done_d;
    end
  end

  // walk pointers and accumulators
  always_ff @(posedge clk_i) begin
    band_q    <= band_d;
    addr_q    <= addr_d;
    hi_q      <= hi_d;
    rd_last_q <= (addr_q == hi_q);
    rd_wt_q   <= wt;
    acc_num_q <= acc_num_d;
    acc_den_q <= acc_den_d;
  end

  // band memory: write on load, registered read during the walk
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mem_q[load_cnt_q] <= band_value_i;
    end
    if (state_q == ST_WALK) begin
      rd_data_q <= mem_q[addr_q];
    end
  end

  // rounding divider
  tbs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .rsp_o  (div_rsp)
  );

  assign result_valid_o   = div_rsp.vld;
  assign smoothed_value_o = div_rsp.value;
  assign last_band_o      = div_rsp.last;

endmodule

// ===== sv/tbs_div.sv =====
// tbs_div: sequential signed rounding divider, two quotient bits a cycle
// depends on tbs_pkg for widths and the request/response structs
`timescale 1ns / 1ps

module tbs_div
  import tbs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output logic     busy_o,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic                 last_q, last_d;
  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [REM_W-2:0]     rem_q, rem_d;
  logic [DEN_W:0]       dvs_q, dvs_d;
  div_rsp_t             rsp_q, rsp_d;

  logic [NUM_W-1:0]     mag;
  logic [REM_W-1:0]     r1, r1n, r2, r2n;
  logic                 ge1, ge2;
  logic [DVD_W-1:0]     d1, d2;
  logic [VAL_W-1:0]     quo;

  // magnitude of the incoming weighted sum
  assign mag = req_i.num[NUM_W-1] ? NUM_W'(-req_i.num) : NUM_W'(req_i.num);

  // two restoring steps
  always_comb begin
    r1  = {rem_q, dvd_q[DVD_W-1]};
    ge1 = (r1 >= {1'b0, dvs_q});
    r1n = ge1 ? (r1 - {1'b0, dvs_q}) : r1;
    d1  = {dvd_q[DVD_W-2:0], ge1};
    r2  = {r1n[REM_W-2:0], d1[DVD_W-1]};
    ge2 = (r2 >= {1'b0, dvs_q});
    r2n = ge2 ? (r2 - {1'b0, dvs_q}) : r2;
    d2  = {d1[DVD_W-2:0], ge2};
    quo = d2[VAL_W-1:0];
  end

  // load, iterate, deliver
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    last_d = last_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    rsp_d  = '0;
    rsp_d.value = rsp_q.value;
    rsp_d.last  = rsp_q.last;
    if (busy_q) begin
      dvd_d = d2;
      rem_d = r2n[REM_W-2:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d      = 1'b0;
        rsp_d.vld   = 1'b1;
        rsp_d.value = neg_q ? (~quo + 1'b1) : quo;
        rsp_d.last  = last_q;
      end
    end else if (req_i.vld) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QDIV_STEPS - 1);
      neg_d  = req_i.num[NUM_W-1];
      last_d = req_i.last;
      dvd_d  = DVD_W'({mag, 1'b0}) + DVD_W'(req_i.den);
      rem_d  = '0;
      dvs_d  = {req_i.den, 1'b0};
    end
  end

  // control state and response word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rsp_q  <= '0;
    end else begin
      busy_q <= busy_d;
      rsp_q  <= rsp_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    last_q <= last_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign rsp_o  = rsp_q;

endmodule
